### rtl/core/triangle_rect_clipper_top_macros.svh
// Assertion helpers for the clipper checker.
`ifndef TRIANGLE_RECT_CLIPPER_TOP_MACROS_SVH
`define TRIANGLE_RECT_CLIPPER_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define TRC_NEVER(label, clk, rst_n, expr, msg) \
    `TRC_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

### rtl/core/trc_pkg.sv
package trc_pkg;

    localparam int MaxPolyVerts = 8;
    localparam int IdxW         = $clog2(MaxPolyVerts);
    localparam int CntW         = $clog2(MaxPolyVerts + 1);
    localparam int AddrW        = IdxW + 1;
    localparam int MaxTris      = 5;
    localparam int TriW         = 3;

    localparam int PosW  = 20;
    localparam int TexW  = 16;
    localparam int ColW  = 8;
    localparam int AttrW = PosW + 1;
    localparam int ProdW = 2 * AttrW;
    localparam int QuoW  = AttrW;
    localparam int RemW  = AttrW + 1;
    localparam int DivCntW = $clog2(QuoW + 1);

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 20;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_LEFT   = 3'd1,
        CFG_TOP    = 3'd2,
        CFG_RIGHT  = 3'd3,
        CFG_BOTTOM = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CORNER_A    = 2'd0,
        CORNER_B    = 2'd1,
        CORNER_C    = 2'd2,
        CORNER_NONE = 2'd3
    } t_corner;

    typedef enum logic [2:0] {
        ATTR_X, ATTR_Y, ATTR_U, ATTR_V, ATTR_R, ATTR_G, ATTR_B, ATTR_A
    } t_attr;

    typedef struct packed {
        logic signed [PosW-1:0] x;
        logic signed [PosW-1:0] y;
        logic [TexW-1:0]        u;
        logic [TexW-1:0]        v;
        logic [ColW-1:0]        r;
        logic [ColW-1:0]        g;
        logic [ColW-1:0]        b;
        logic [ColW-1:0]        a;
    } t_vtx;

    localparam int VtxW = $bits(t_vtx);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_COPY, S_E_START, S_E_LDA, S_E_NEXT, S_E_LDB, S_E_EVAL,
        S_X_SETUP, S_X_START, S_X_WAIT, S_X_WR, S_E_ADV, S_E_DONE, S_FIN,
        S_F_RD, S_F_LD, S_F_OUT
    } t_state;

    typedef enum logic [1:0] {
        L_IDLE, L_MUL, L_PREP, L_DIV
    } t_lerp_state;

    typedef struct packed {
        logic                    start;
        logic signed [AttrW-1:0] a0;
        logic signed [AttrW-1:0] a1;
        logic signed [AttrW-1:0] num;
        logic signed [AttrW-1:0] den;
    } t_lerp_req;

    typedef struct packed {
        logic                    done;
        logic signed [AttrW-1:0] result;
    } t_lerp_rsp;

    function automatic logic signed [AttrW-1:0] vtx_attr(input t_vtx vx, input t_attr k);
        logic signed [AttrW-1:0] val;
        val = '0;
        case (k)
            ATTR_X:  val = AttrW'(vx.x);
            ATTR_Y:  val = AttrW'(vx.y);
            ATTR_U:  val = AttrW'(vx.u);
            ATTR_V:  val = AttrW'(vx.v);
            ATTR_R:  val = AttrW'(vx.r);
            ATTR_G:  val = AttrW'(vx.g);
            ATTR_B:  val = AttrW'(vx.b);
            default: val = AttrW'(vx.a);
        endcase
        return val;
    endfunction

    function automatic t_vtx vtx_set(input t_vtx vx, input t_attr k,
                                     input logic signed [AttrW-1:0] val);
        t_vtx res;
        res = vx;
        case (k)
            ATTR_X:  res.x = val[PosW-1:0];
            ATTR_Y:  res.y = val[PosW-1:0];
            ATTR_U:  res.u = val[TexW-1:0];
            ATTR_V:  res.v = val[TexW-1:0];
            ATTR_R:  res.r = val[ColW-1:0];
            ATTR_G:  res.g = val[ColW-1:0];
            ATTR_B:  res.b = val[ColW-1:0];
            default: res.a = val[ColW-1:0];
        endcase
        return res;
    endfunction

endpackage

### rtl/core/trc_vstore.sv
module trc_vstore (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [trc_pkg::AddrW-1:0] i_waddr,
    input  trc_pkg::t_vtx            i_wdata,
    input  logic [trc_pkg::AddrW-1:0] i_raddr,
    output trc_pkg::t_vtx            o_rdata
);

    // two polygon banks, ping-ponged between clip edges
    trc_pkg::t_vtx r_mem [2*trc_pkg::MaxPolyVerts];
    trc_pkg::t_vtx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/trc_lerp.sv
module trc_lerp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trc_pkg::t_lerp_req  i_req,
    output trc_pkg::t_lerp_rsp  o_rsp
);

    localparam int AttrW   = trc_pkg::AttrW;
    localparam int ProdW   = trc_pkg::ProdW;
    localparam int QuoW    = trc_pkg::QuoW;
    localparam int RemW    = trc_pkg::RemW;
    localparam int DivCntW = trc_pkg::DivCntW;

    trc_pkg::t_lerp_state r_state, n_state;

    logic signed [AttrW-1:0] r_a0, r_d, r_num, r_den;
    logic signed [ProdW-1:0] r_p;
    logic [AttrW-1:0]        r_md;
    logic                    r_neg;
    logic [RemW-1:0]         r_rem;
    logic [QuoW-1:0]         r_lo;
    logic [DivCntW-1:0]      r_cnt;

    logic [ProdW-1:0]        mp;
    logic [RemW-1:0]         trial;
    logic                    qbit;
    logic [AttrW-1:0]        quo;
    logic signed [AttrW-1:0] rnd;
    logic                    div_last;

    assign mp       = r_p[ProdW-1] ? ProdW'(-r_p) : ProdW'(r_p);
    assign trial    = {r_rem[RemW-2:0], r_lo[QuoW-1]};
    assign qbit     = trial >= RemW'(r_md);
    assign div_last = r_cnt == DivCntW'(QuoW - 1);

    // final step: round half away from zero on magnitude, then restore sign
    always_comb begin
        quo  = AttrW'({r_lo[QuoW-2:0], qbit});
        if ({(qbit ? RemW'(trial - RemW'(r_md)) : trial), 1'b0} >= (RemW+1)'(r_md)) begin
            quo = quo + AttrW'(1);
        end
        rnd = r_neg ? AttrW'(-$signed(quo)) : AttrW'($signed(quo));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trc_pkg::L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_rsp.done   = 1'b0;
        o_rsp.result = AttrW'(r_a0 + rnd);
        unique case (r_state)
            trc_pkg::L_IDLE: begin
                if (i_req.start) begin
                    n_state = trc_pkg::L_MUL;
                end
            end
            trc_pkg::L_MUL:  n_state = trc_pkg::L_PREP;
            trc_pkg::L_PREP: n_state = trc_pkg::L_DIV;
            trc_pkg::L_DIV: begin
                if (div_last) begin
                    o_rsp.done = 1'b1;
                    n_state    = trc_pkg::L_IDLE;
                end
            end
            default: n_state = trc_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            trc_pkg::L_IDLE: begin
                r_a0  <= i_req.a0;
                r_d   <= AttrW'(i_req.a1 - i_req.a0);
                r_num <= i_req.num;
                r_den <= i_req.den;
            end
            trc_pkg::L_MUL: begin
                r_p  <= ProdW'(r_d) * ProdW'(r_num);
                r_md <= r_den[AttrW-1] ? AttrW'(-r_den) : AttrW'(r_den);
            end
            trc_pkg::L_PREP: begin
                r_neg <= (r_p != '0) && (r_p[ProdW-1] != r_den[AttrW-1]);
                // quotient fits QuoW bits, so the upper part is already below the divisor
                r_rem <= RemW'(mp >> QuoW);
                r_lo  <= mp[QuoW-1:0];
                r_cnt <= '0;
            end
            default: begin
                r_rem <= qbit ? RemW'(trial - RemW'(r_md)) : trial;
                r_lo  <= {r_lo[QuoW-2:0], qbit};
                r_cnt <= r_cnt + DivCntW'(1);
            end
        endcase
    end

endmodule

### rtl/core/triangle_rect_clipper_top.sv
// Triangle clipper against an axis-aligned rectangle.
// Input channel (i_valid/o_ready) takes one vertex per transfer; i_corner
// selects corner 0, 1 or 2, and corner 2 closes the triangle. Corner code 3
// is ignored. After corner 0 or 1 the block stays ready for more input.
// Output channel (o_valid/i_ready) gives the clipped polygon as a triangle
// fan, three vertices per fan triangle, o_last_vertex on the final one.
// Registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata; the user
// must write them only while idle, as the block does not enforce it. For a
// passing triangle the corners are checked and copied to the store, then
// the first fan vertex is read and presented. Each clip crossing runs every
// attribute but the clipped axis through the shared interpolation unit
// (multiply, then one quotient bit per cycle over 21 bits). The vertex store
// is read once per emitted vertex. The block takes no input until the last
// vertex of a triangle is transferred.
// Reset clears the registers and the sequencer; stored corners are kept as
// undefined until written. A stalled receiver holds the output vertex and
// the sequencer waits.
module triangle_rect_clipper_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [trc_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [trc_pkg::CfgDataW-1:0]  i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_corner,
    input  logic signed [trc_pkg::PosW-1:0] i_pos_x,
    input  logic signed [trc_pkg::PosW-1:0] i_pos_y,
    input  logic [trc_pkg::TexW-1:0]      i_tex_u,
    input  logic [trc_pkg::TexW-1:0]      i_tex_v,
    input  logic [trc_pkg::ColW-1:0]      i_col_r,
    input  logic [trc_pkg::ColW-1:0]      i_col_g,
    input  logic [trc_pkg::ColW-1:0]      i_col_b,
    input  logic [trc_pkg::ColW-1:0]      i_col_a,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [trc_pkg::PosW-1:0] o_out_x,
    output logic signed [trc_pkg::PosW-1:0] o_out_y,
    output logic [trc_pkg::TexW-1:0]      o_out_u,
    output logic [trc_pkg::TexW-1:0]      o_out_v,
    output logic [trc_pkg::ColW-1:0]      o_out_r,
    output logic [trc_pkg::ColW-1:0]      o_out_g,
    output logic [trc_pkg::ColW-1:0]      o_out_b,
    output logic [trc_pkg::ColW-1:0]      o_out_a,
    output logic                          o_last_vertex
);

    localparam int PosW  = trc_pkg::PosW;
    localparam int AttrW = trc_pkg::AttrW;
    localparam int CntW  = trc_pkg::CntW;
    localparam int IdxW  = trc_pkg::IdxW;
    localparam int AddrW = trc_pkg::AddrW;
    localparam int TriW  = trc_pkg::TriW;

    trc_pkg::t_state r_state, n_state;

    logic                   r_en;
    logic signed [PosW-1:0] r_left, r_top, r_right, r_bottom;
    trc_pkg::t_vtx          r_c0, r_c1, r_c2;
    trc_pkg::t_vtx          r_va, r_vb, r_first, r_w, r_out;
    logic                   r_s;
    logic [1:0]             r_e;
    logic [CntW-1:0]        r_i, r_n, r_cnt;
    trc_pkg::t_attr         r_k;
    logic [TriW-1:0]        r_tris, r_tri;
    logic [1:0]             r_j;
    logic                   r_pass;
    logic                   r_ovld;
    logic                   r_last;

    trc_pkg::t_vtx          in_vtx, rdata, wdata;
    logic                   we;
    logic [AddrW-1:0]       waddr, raddr;
    trc_pkg::t_lerp_req     lreq;
    trc_pkg::t_lerp_rsp     lrsp;

    logic                    in_acc;
    logic                    lower;
    trc_pkg::t_attr          ax_attr;
    logic signed [AttrW-1:0] bound, va_ax, vb_ax;
    logic                    ia, ib;
    logic                    n_room;
    logic signed [PosW-1:0]  mnx, mny, mxx, mxy;
    logic                    drop, pass;
    logic [CntW-1:0]         tris_raw;
    logic [CntW-1:0]         fan_idx;

    function automatic logic signed [PosW-1:0] min3(input logic signed [PosW-1:0] a,
                                                    input logic signed [PosW-1:0] b,
                                                    input logic signed [PosW-1:0] c);
        logic signed [PosW-1:0] m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    function automatic logic signed [PosW-1:0] max3(input logic signed [PosW-1:0] a,
                                                    input logic signed [PosW-1:0] b,
                                                    input logic signed [PosW-1:0] c);
        logic signed [PosW-1:0] m;
        m = (b > a) ? b : a;
        return (c > m) ? c : m;
    endfunction

    assign in_vtx = '{x: i_pos_x, y: i_pos_y, u: i_tex_u, v: i_tex_v,
                      r: i_col_r, g: i_col_g, b: i_col_b, a: i_col_a};

    assign o_ready = r_state == trc_pkg::S_IDLE;
    assign in_acc  = i_valid && o_ready;

    // edge order: left, right, top, bottom
    assign lower   = ~r_e[0];
    assign ax_attr = r_e[1] ? trc_pkg::ATTR_Y : trc_pkg::ATTR_X;
    always_comb begin
        case (r_e)
            2'd0:    bound = AttrW'(r_left);
            2'd1:    bound = AttrW'(r_right);
            2'd2:    bound = AttrW'(r_top);
            default: bound = AttrW'(r_bottom);
        endcase
    end
    assign va_ax  = trc_pkg::vtx_attr(r_va, ax_attr);
    assign vb_ax  = trc_pkg::vtx_attr(r_vb, ax_attr);
    assign ia     = lower ? (va_ax >= bound) : (va_ax <= bound);
    assign ib     = lower ? (vb_ax >= bound) : (vb_ax <= bound);
    assign n_room = r_n < CntW'(trc_pkg::MaxPolyVerts);

    assign mnx  = min3(r_c0.x, r_c1.x, r_c2.x);
    assign mny  = min3(r_c0.y, r_c1.y, r_c2.y);
    assign mxx  = max3(r_c0.x, r_c1.x, r_c2.x);
    assign mxy  = max3(r_c0.y, r_c1.y, r_c2.y);
    assign drop = r_en && (mnx > r_right || mny > r_bottom || mxx < r_left || mxy < r_top);
    assign pass = !r_en || (mnx >= r_left && mny >= r_top && mxx <= r_right && mxy <= r_bottom);

    assign tris_raw = r_cnt - CntW'(2);
    assign fan_idx  = (r_j == 2'd0) ? '0 : CntW'(r_tri) + CntW'(r_j) - CntW'(1);

    trc_vstore u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    trc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lreq),
        .o_rsp   (lrsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= trc_pkg::S_IDLE;
            r_en     <= 1'b0;
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    trc_pkg::CFG_ENABLE: r_en     <= i_cfg_wdata[0];
                    trc_pkg::CFG_LEFT:   r_left   <= i_cfg_wdata;
                    trc_pkg::CFG_TOP:    r_top    <= i_cfg_wdata;
                    trc_pkg::CFG_RIGHT:  r_right  <= i_cfg_wdata;
                    trc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == trc_pkg::S_F_LD) begin
                r_ovld <= 1'b1;
            end else if (r_state == trc_pkg::S_F_OUT && i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // sequencer: next state and store / interpolator control
    always_comb begin
        n_state    = r_state;
        we         = 1'b0;
        waddr      = {~r_s, r_n[IdxW-1:0]};
        wdata      = r_va;
        raddr      = {r_s, r_i[IdxW-1:0] + IdxW'(1)};
        lreq.start = 1'b0;
        lreq.a0    = trc_pkg::vtx_attr(r_va, r_k);
        lreq.a1    = trc_pkg::vtx_attr(r_vb, r_k);
        lreq.num   = AttrW'(bound - va_ax);
        lreq.den   = AttrW'(vb_ax - va_ax);
        unique case (r_state)
            trc_pkg::S_IDLE: begin
                if (in_acc && i_corner == trc_pkg::CORNER_C) begin
                    n_state = trc_pkg::S_CHECK;
                end
            end
            trc_pkg::S_CHECK: n_state = drop ? trc_pkg::S_IDLE : trc_pkg::S_COPY;
            trc_pkg::S_COPY: begin
                we    = 1'b1;
                waddr = {1'b0, r_i[IdxW-1:0]};
                case (r_i[1:0])
                    2'd0:    wdata = r_c0;
                    2'd1:    wdata = r_c1;
                    default: wdata = r_c2;
                endcase
                if (r_i == CntW'(2)) begin
                    n_state = r_pass ? trc_pkg::S_FIN : trc_pkg::S_E_START;
                end
            end
            trc_pkg::S_E_START: begin
                raddr   = {r_s, {IdxW{1'b0}}};
                n_state = trc_pkg::S_E_LDA;
            end
            trc_pkg::S_E_LDA: n_state = trc_pkg::S_E_NEXT;
            trc_pkg::S_E_NEXT: begin
                n_state = (r_i + CntW'(1) == r_cnt) ? trc_pkg::S_E_EVAL : trc_pkg::S_E_LDB;
            end
            trc_pkg::S_E_LDB: n_state = trc_pkg::S_E_EVAL;
            trc_pkg::S_E_EVAL: begin
                we      = ia && n_room;
                n_state = (ia != ib) ? trc_pkg::S_X_SETUP : trc_pkg::S_E_ADV;
            end
            trc_pkg::S_X_SETUP: n_state = n_room ? trc_pkg::S_X_START : trc_pkg::S_E_ADV;
            trc_pkg::S_X_START: begin
                if (r_k == ax_attr) begin
                    if (r_k == trc_pkg::ATTR_A) begin
                        n_state = trc_pkg::S_X_WR;
                    end
                end else begin
                    lreq.start = 1'b1;
                    n_state    = trc_pkg::S_X_WAIT;
                end
            end
            trc_pkg::S_X_WAIT: begin
                if (lrsp.done) begin
                    n_state = (r_k == trc_pkg::ATTR_A) ? trc_pkg::S_X_WR : trc_pkg::S_X_START;
                end
            end
            trc_pkg::S_X_WR: begin
                we      = 1'b1;
                wdata   = trc_pkg::vtx_set(r_w, ax_attr, bound);
                n_state = trc_pkg::S_E_ADV;
            end
            trc_pkg::S_E_ADV: begin
                n_state = (r_i + CntW'(1) == r_cnt) ? trc_pkg::S_E_DONE : trc_pkg::S_E_NEXT;
            end
            trc_pkg::S_E_DONE: begin
                n_state = (r_e == 2'd3 || r_n == '0) ? trc_pkg::S_FIN : trc_pkg::S_E_START;
            end
            trc_pkg::S_FIN: begin
                n_state = (r_cnt < CntW'(3)) ? trc_pkg::S_IDLE : trc_pkg::S_F_RD;
            end
            trc_pkg::S_F_RD: begin
                raddr   = {r_s, fan_idx[IdxW-1:0]};
                n_state = trc_pkg::S_F_LD;
            end
            trc_pkg::S_F_LD: n_state = trc_pkg::S_F_OUT;
            trc_pkg::S_F_OUT: begin
                if (i_ready) begin
                    n_state = r_last ? trc_pkg::S_IDLE : trc_pkg::S_F_RD;
                end
            end
            default: n_state = trc_pkg::S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            trc_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_corner)
                        trc_pkg::CORNER_A: r_c0 <= in_vtx;
                        trc_pkg::CORNER_B: r_c1 <= in_vtx;
                        trc_pkg::CORNER_C: r_c2 <= in_vtx;
                        default: ;
                    endcase
                end
            end
            trc_pkg::S_CHECK: begin
                r_pass <= pass;
                r_i    <= '0;
                r_s    <= 1'b0;
                r_e    <= 2'd0;
                r_n    <= '0;
                r_cnt  <= CntW'(3);
            end
            trc_pkg::S_COPY: r_i <= r_i + CntW'(1);
            trc_pkg::S_E_LDA: begin
                r_va    <= rdata;
                r_first <= rdata;
                r_i     <= '0;
            end
            trc_pkg::S_E_NEXT: begin
                if (r_i + CntW'(1) == r_cnt) begin
                    r_vb <= r_first;
                end
            end
            trc_pkg::S_E_LDB: r_vb <= rdata;
            trc_pkg::S_E_EVAL: begin
                if (ia && n_room) begin
                    r_n <= r_n + CntW'(1);
                end
                r_w <= r_va;
                r_k <= trc_pkg::ATTR_X;
            end
            trc_pkg::S_X_START: begin
                if (r_k == ax_attr && r_k != trc_pkg::ATTR_A) begin
                    r_k <= trc_pkg::t_attr'(r_k + 3'd1);
                end
            end
            trc_pkg::S_X_WAIT: begin
                if (lrsp.done) begin
                    r_w <= trc_pkg::vtx_set(r_w, r_k, lrsp.result);
                    if (r_k != trc_pkg::ATTR_A) begin
                        r_k <= trc_pkg::t_attr'(r_k + 3'd1);
                    end
                end
            end
            trc_pkg::S_X_WR: r_n <= r_n + CntW'(1);
            trc_pkg::S_E_ADV: begin
                r_i  <= r_i + CntW'(1);
                r_va <= r_vb;
            end
            trc_pkg::S_E_DONE: begin
                r_cnt <= r_n;
                r_s   <= ~r_s;
                r_n   <= '0;
                r_e   <= r_e + 2'd1;
            end
            trc_pkg::S_FIN: begin
                r_tris <= (tris_raw > CntW'(trc_pkg::MaxTris)) ? TriW'(trc_pkg::MaxTris)
                                                                : TriW'(tris_raw);
                r_tri  <= TriW'(1);
                r_j    <= 2'd0;
            end
            trc_pkg::S_F_LD: begin
                r_out  <= rdata;
                r_last <= (r_tri == r_tris) && (r_j == 2'd2);
            end
            trc_pkg::S_F_OUT: begin
                if (i_ready) begin
                    if (r_j == 2'd2) begin
                        r_j   <= 2'd0;
                        r_tri <= r_tri + TriW'(1);
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ovld;
    assign o_out_x       = r_out.x;
    assign o_out_y       = r_out.y;
    assign o_out_u       = r_out.u;
    assign o_out_v       = r_out.v;
    assign o_out_r       = r_out.r;
    assign o_out_g       = r_out.g;
    assign o_out_b       = r_out.b;
    assign o_out_a       = r_out.a;
    assign o_last_vertex = r_last;

endmodule

### rtl/core/trc_checker.sv
`include "triangle_rect_clipper_top_macros.svh"

module trc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [1:0]                  i_corner,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [trc_pkg::PosW-1:0]    o_out_x,
    input logic                        o_last_vertex
);

    `TRC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_last_vertex), "stalled output changed")
    `TRC_NEVER(a_busy_while_out, i_clk, i_rst_n, o_ready && o_valid, "input ready while a vertex is pending")
    `TRC_ASSERT(a_gap_after_out, i_clk, i_rst_n, o_valid && i_ready |=> !o_valid, "output valid right after a transfer")
    `TRC_ASSERT(a_store_keeps_ready, i_clk, i_rst_n, i_valid && o_ready && (i_corner != trc_pkg::CORNER_C) |=> o_ready, "corner store left idle")

endmodule

bind triangle_rect_clipper_top trc_checker u_trc_checker (.*);
